// ===== rtl/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// iaf_pkg
// shared constants, types and codes for the integer to ascii formatter
// ----------------------------------------------------------------------------
package iaf_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int MAX_WIDTH   = 62;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_VALUE_W = 64;
    localparam int WIDTH_W    = 6;
    localparam int CH_W       = 8;

    localparam int DIG_BITS = MAX_DIGITS * 4;
    localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W    = $clog2(MAX_DIGITS);
    localparam int BIT_W    = $clog2(VALUE_BITS);
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_X     = 8'h78;
    localparam logic [CH_W-1:0] CH_A     = 8'h61;

    typedef enum logic [1:0] {
        CONV_UDEC = 2'd0,
        CONV_SDEC = 2'd1,
        CONV_HEX  = 2'd2,
        CONV_PTR  = 2'd3
    } t_conv;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DABBLE,
        FS_SCAN,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SIGN,
        BS_PREFIX0,
        BS_PREFIXX,
        BS_PAD,
        BS_DIGITS
    } t_back_state;

    // one classified and converted request, ready to be printed
    typedef struct packed {
        logic [DIG_BITS-1:0] digits;
        logic [CNT_W-1:0]    count;
        logic [WIDTH_W-1:0]  pad;
        logic                neg;
        logic                prefix;
        logic                zpad;
    } t_job;

endpackage

// ===== rtl/iaf_front.sv =====
// ----------------------------------------------------------------------------
// iaf_front
// accepts requests, classifies them and converts the magnitude to digits
// ----------------------------------------------------------------------------
module iaf_front import iaf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [1:0]            i_conversion,
    input  logic                  i_zero_pad,
    input  logic [WIDTH_W-1:0]    i_width,
    output logic                  o_job_valid,
    input  logic                  i_job_full,
    output t_job                  o_job
);

    t_front_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_shift, n_shift;
    logic [DIG_BITS-1:0]   r_bcd, n_bcd;
    logic                  r_ovf, n_ovf;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [WIDTH_W-1:0]    r_width, n_width;
    logic                  r_neg, n_neg;
    logic                  r_prefix, n_prefix;
    logic                  r_zpad, n_zpad;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [WIDTH_W-1:0]    r_pad, n_pad;

    logic [VALUE_BITS-1:0]          w_val;
    logic [VALUE_BITS-1:0]          w_mag;
    logic                           w_neg;
    logic [WIDTH_W-1:0]             w_wsat;
    logic [DIG_BITS+VALUE_BITS-1:0] w_ext;
    logic [DIG_BITS-1:0]            w_adj;
    logic [3:0]                     w_scan_digit;
    logic [CNT_W-1:0]               w_scan_count;
    logic [WIDTH_W:0]               w_w_ext;
    logic [WIDTH_W:0]               w_c_ext;

    assign w_val  = i_value[VALUE_BITS-1:0];
    assign w_neg  = (t_conv'(i_conversion) == CONV_SDEC) && w_val[VALUE_BITS-1];
    assign w_mag  = w_neg ? (~w_val + VALUE_BITS'(1)) : w_val;
    assign w_wsat = (i_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : i_width;
    assign w_ext  = {{DIG_BITS{1'b0}}, w_mag};

    // add-3 correction, each digit on its own
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    assign w_scan_digit = r_bcd[{r_idx, 2'b00} +: 4];
    assign w_scan_count = r_ovf ? CNT_W'(MAX_DIGITS) : (CNT_W'(r_idx) + CNT_W'(1));
    assign w_w_ext      = {1'b0, r_width};
    assign w_c_ext      = (WIDTH_W + 1)'(w_scan_count);

    always_comb begin
        n_state  = r_state;
        n_shift  = r_shift;
        n_bcd    = r_bcd;
        n_ovf    = r_ovf;
        n_bit    = r_bit;
        n_idx    = r_idx;
        n_width  = r_width;
        n_neg    = r_neg;
        n_prefix = r_prefix;
        n_zpad   = r_zpad;
        n_count  = r_count;
        n_pad    = r_pad;
        case (r_state)
            FS_IDLE: begin
                if (i_push) begin
                    n_neg    = w_neg;
                    n_prefix = (t_conv'(i_conversion) == CONV_PTR);
                    n_zpad   = i_zero_pad;
                    n_width  = (w_neg && (w_wsat != '0)) ? (w_wsat - WIDTH_W'(1)) : w_wsat;
                    n_idx    = IDX_W'(MAX_DIGITS - 1);
                    n_shift  = w_mag;
                    n_bit    = BIT_W'(VALUE_BITS - 1);
                    if (t_conv'(i_conversion) inside {CONV_HEX, CONV_PTR}) begin
                        n_bcd   = w_ext[DIG_BITS-1:0];
                        n_ovf   = |w_ext[DIG_BITS+VALUE_BITS-1:DIG_BITS];
                        n_state = FS_SCAN;
                    end else begin
                        n_bcd   = '0;
                        n_ovf   = 1'b0;
                        n_state = FS_DABBLE;
                    end
                end
            end
            FS_DABBLE: begin
                n_bcd   = {w_adj[DIG_BITS-2:0], r_shift[VALUE_BITS-1]};
                n_ovf   = r_ovf | w_adj[DIG_BITS-1];
                n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_bit   = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = FS_SCAN;
                end
            end
            FS_SCAN: begin
                // walk down from the top digit to the first nonzero one
                if (r_ovf || (w_scan_digit != 4'd0) || (r_idx == '0)) begin
                    n_count = w_scan_count;
                    n_pad   = (w_w_ext > w_c_ext) ? WIDTH_W'(w_w_ext - w_c_ext) : '0;
                    n_state = FS_PUSH;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            FS_PUSH: begin
                if (!i_job_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_bcd    <= n_bcd;
        r_ovf    <= n_ovf;
        r_bit    <= n_bit;
        r_idx    <= n_idx;
        r_width  <= n_width;
        r_neg    <= n_neg;
        r_prefix <= n_prefix;
        r_zpad   <= n_zpad;
        r_count  <= n_count;
        r_pad    <= n_pad;
    end

    assign o_full       = (r_state != FS_IDLE);
    assign o_job_valid  = (r_state == FS_PUSH);
    assign o_job.digits = r_bcd;
    assign o_job.count  = r_count;
    assign o_job.pad    = r_pad;
    assign o_job.neg    = r_neg;
    assign o_job.prefix = r_prefix;
    assign o_job.zpad   = r_zpad;

endmodule

// ===== rtl/iaf_queue.sv =====
// ----------------------------------------------------------------------------
// iaf_queue
// short fifo of converted requests between front and back
// ----------------------------------------------------------------------------
module iaf_queue import iaf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (r_wr_ptr + QPTR_W'(1));
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (r_rd_ptr + QPTR_W'(1));
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/iaf_back.sv =====
// ----------------------------------------------------------------------------
// iaf_back
// prints one converted request as a stream of characters
// ----------------------------------------------------------------------------
module iaf_back import iaf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    input  t_job            i_job,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [CH_W-1:0] o_ch,
    output logic            o_last
);

    t_back_state r_state, n_state;

    t_job               r_job, n_job;
    logic [WIDTH_W-1:0] r_pad, n_pad;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic               r_last, n_last;

    logic        w_slot;
    logic [3:0]  w_digit;
    t_back_state w_after_prefix;
    t_back_state w_after_sign;
    t_back_state w_first;

    assign w_slot  = !r_valid || i_pop;
    assign w_digit = r_job.digits[{r_idx, 2'b00} +: 4];

    assign w_after_prefix = (r_pad != '0) ? BS_PAD : BS_DIGITS;
    assign w_after_sign   = r_job.prefix ? BS_PREFIX0 : w_after_prefix;

    always_comb begin
        if (i_job.neg) begin
            w_first = BS_SIGN;
        end else if (i_job.prefix) begin
            w_first = BS_PREFIX0;
        end else if (i_job.pad != '0) begin
            w_first = BS_PAD;
        end else begin
            w_first = BS_DIGITS;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_pad     = r_pad;
        n_idx     = r_idx;
        n_valid   = r_valid && !i_pop;
        n_ch      = r_ch;
        n_last    = r_last;
        o_job_pop = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_pad     = i_job.pad;
                    n_idx     = IDX_W'(i_job.count - CNT_W'(1));
                    n_state   = w_first;
                end
            end
            BS_SIGN: begin
                if (w_slot) begin
                    n_valid = 1'b1;
                    n_ch    = CH_MINUS;
                    n_last  = 1'b0;
                    n_state = w_after_sign;
                end
            end
            BS_PREFIX0: begin
                if (w_slot) begin
                    n_valid = 1'b1;
                    n_ch    = CH_ZERO;
                    n_last  = 1'b0;
                    n_state = BS_PREFIXX;
                end
            end
            BS_PREFIXX: begin
                if (w_slot) begin
                    n_valid = 1'b1;
                    n_ch    = CH_X;
                    n_last  = 1'b0;
                    n_state = w_after_prefix;
                end
            end
            BS_PAD: begin
                if (w_slot) begin
                    n_valid = 1'b1;
                    n_ch    = r_job.zpad ? CH_ZERO : CH_SPACE;
                    n_last  = 1'b0;
                    n_pad   = r_pad - WIDTH_W'(1);
                    if (r_pad == WIDTH_W'(1)) begin
                        n_state = BS_DIGITS;
                    end
                end
            end
            BS_DIGITS: begin
                if (w_slot) begin
                    n_valid = 1'b1;
                    if (w_digit < 4'd10) begin
                        n_ch = CH_ZERO + CH_W'(w_digit);
                    end else begin
                        n_ch = CH_A + CH_W'(w_digit - 4'd10);
                    end
                    n_last = (r_idx == '0);
                    n_idx  = r_idx - IDX_W'(1);
                    if (r_idx == '0) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_pad  <= n_pad;
        r_idx  <= n_idx;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    assign o_empty = !r_valid;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

endmodule

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// printf style integer conversion with field width and padding
// ----------------------------------------------------------------------------
// Each request carries a value, a conversion kind (unsigned decimal, signed
// decimal, hex, or hex with a 0x prefix), a zero-pad flag and a field width;
// it comes back as a stream of ascii characters, one per result, with last
// set on the final one. The front converts the magnitude: a decimal request
// is accepted, runs VALUE_BITS shift-and-add-3 steps, scans down for the
// leading digit and is handed to the queue; a hex request skips the shifting
// and always walks past the four top digits. The back takes a job from
// a two-entry queue and then gives one character per cycle while pop keeps
// up (at most 64 characters). The two halves overlap, so the front can
// convert the next request while the back still prints. full is high while
// the front works on a request.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit import iaf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [1:0]            i_conversion,
    input  logic                  i_zero_pad,
    input  logic [WIDTH_W-1:0]    i_width,
    // character side
    output logic                  empty,
    input  logic                  pop,
    output logic [CH_W-1:0]       o_ch,
    output logic                  o_last
);

    // converted jobs between front and queue
    t_job w_front_job;
    logic w_front_valid;
    logic w_queue_full;

    // jobs between queue and back
    t_job w_back_job;
    logic w_queue_empty;
    logic w_back_pop;

    // classify and convert to digits
    iaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_value      (i_value),
        .i_conversion (i_conversion),
        .i_zero_pad   (i_zero_pad),
        .i_width      (i_width),
        .o_job_valid  (w_front_valid),
        .i_job_full   (w_queue_full),
        .o_job        (w_front_job)
    );

    // lets the front start the next conversion while the back still prints
    iaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .o_full  (w_queue_full),
        .i_job   (w_front_job),
        .i_pop   (w_back_pop),
        .o_empty (w_queue_empty),
        .o_job   (w_back_job)
    );

    // sign, prefix, padding and digits out through a registered slot
    iaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_queue_empty),
        .o_job_pop   (w_back_pop),
        .i_job       (w_back_job),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_ch        (o_ch),
        .o_last      (o_last)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the integer to ascii formatter
// ----------------------------------------------------------------------------
// Each request is sent through the push/full queue port and formatted
// independently in the bench to build the expected character stream. Every
// character popped from the unit is compared against the oldest expected
// character, both ch and last. The run starts with directed requests that
// cover each conversion kind and the corner cases of sign, zero, saturation
// and digit count. Random requests follow in three flow-control phases:
// first a mostly idle receiver, then a mostly idle sender, then no idling on
// either side.
// ----------------------------------------------------------------------------
module testbench import iaf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // longest character stream one request can produce
    localparam int MAX_CHARS    = 64;
    // front conversion plus a full stream, with margin
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_char_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [IN_VALUE_W-1:0] i_value;
    logic [1:0]            i_conversion;
    logic                  i_zero_pad;
    logic [WIDTH_W-1:0]    i_width;
    logic                  empty;
    logic                  pop;
    logic [CH_W-1:0]       o_ch;
    logic                  o_last;

    // characters still owed by the unit, oldest first
    t_char_out expected_chars[$];

    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int chars_checked;
    int error_count;
    int cycle_count;

    integer_to_ascii_formatter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .i_conversion (i_conversion),
        .i_zero_pad   (i_zero_pad),
        .i_width      (i_width),
        .empty        (empty),
        .pop          (pop),
        .o_ch         (o_ch),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // formatting predictor: builds the character stream of one request
    // ------------------------------------------------------------------
    function automatic void format_expected(input logic [IN_VALUE_W-1:0] value,
                                            input t_conv conv,
                                            input logic zpad,
                                            input logic [WIDTH_W-1:0] width);
        logic [IN_VALUE_W-1:0] mask;
        logic [IN_VALUE_W-1:0] mag;
        logic [IN_VALUE_W-1:0] base;
        logic [3:0]            digit_buf [MAX_DIGITS];
        logic                  neg;
        int                    n_digits;
        int                    field;
        int                    n_pad;
        int                    i;
        t_char_out             c;
        t_char_out             stream[$];

        mask = {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - VALUE_BITS);
        mag  = value & mask;
        base = (conv == CONV_HEX || conv == CONV_PTR) ? 64'd16 : 64'd10;
        // field width saturates at the maximum
        field = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);

        // negative signed: magnitude, and the sign eats one column
        neg = (conv == CONV_SDEC) && mag[VALUE_BITS-1];
        if (neg) begin
            mag = (~mag + 64'd1) & mask;
            if (field > 0)
                field--;
        end

        // digits, least significant first; zero still yields one digit
        n_digits = 0;
        do begin
            digit_buf[n_digits] = 4'(mag % base);
            mag = mag / base;
            n_digits++;
        end while (mag != 0 && n_digits < MAX_DIGITS);

        n_pad = (field > n_digits) ? field - n_digits : 0;

        c.last = 1'b0;
        if (neg) begin
            c.ch = CH_MINUS;
            stream.push_back(c);
        end
        // the 0x prefix sits outside the field width
        if (conv == CONV_PTR) begin
            c.ch = CH_ZERO;
            stream.push_back(c);
            c.ch = CH_X;
            stream.push_back(c);
        end
        for (i = 0; i < n_pad; i++) begin
            c.ch = zpad ? CH_ZERO : CH_SPACE;
            stream.push_back(c);
        end
        for (i = n_digits - 1; i >= 0; i--) begin
            if (digit_buf[i] < 10)
                c.ch = CH_W'(CH_ZERO + digit_buf[i]);
            else
                c.ch = CH_W'(CH_A + digit_buf[i] - 10);
            stream.push_back(c);
        end

        while (stream.size() > MAX_CHARS)
            void'(stream.pop_back());
        stream[stream.size() - 1].last = 1'b1;

        foreach (stream[k])
            expected_chars.push_back(stream[k]);
    endfunction

    // ------------------------------------------------------------------
    // request driver: optional idle gap, then hold push until accepted
    // ------------------------------------------------------------------
    task automatic send_request(input logic [IN_VALUE_W-1:0] value,
                                input t_conv conv,
                                input logic zpad,
                                input logic [WIDTH_W-1:0] width);
        int gap;

        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end

        // push stays high straight into the next request when no gap is drawn
        push         <= 1'b1;
        i_value      <= value;
        i_conversion <= conv;
        i_zero_pad   <= zpad;
        i_width      <= width;
        @(posedge i_clk);
        while (full !== 1'b0)
            @(posedge i_clk);

        format_expected(value, conv, zpad, width);
        requests_sent++;
    endtask

    task automatic note_failure(input string what, input t_char_out want,
                                input t_char_out got);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] %s: expected ch=%h last=%b, got ch=%h last=%b",
                     $realtime, what, want.ch, want.last, got.ch, got.last);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // character side: random pop and the checker on every accepted pop
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_out want;
        t_char_out got;

        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop === 1'b1 && empty === 1'b0) begin
                got.ch   = o_ch;
                got.last = o_last;
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    // the unit produced a character nobody asked for
                    want = '0;
                    note_failure("unexpected character", want, got);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last)
                        note_failure("character mismatch", want, got);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still owed",
                     cycle_count, expected_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // each conversion kind on plain values, zero included
    task automatic test_conversion_kinds();
        send_request(64'd0, CONV_UDEC, 1'b0, 6'd0);
        send_request(64'd0, CONV_SDEC, 1'b1, 6'd5);
        send_request(64'd0, CONV_HEX, 1'b0, 6'd0);
        send_request(64'd0, CONV_PTR, 1'b1, 6'd3);
        send_request(64'd12345, CONV_SDEC, 1'b0, 6'd8);
        send_request(64'hffff_ffff_ffff_ffff, CONV_HEX, 1'b0, 6'd0);
        send_request(64'h0123_4567_89ab_cdef, CONV_HEX, 1'b1, 6'd20);
        send_request(64'h7fff_ffff_ffff_ffff, CONV_SDEC, 1'b0, 6'd0);
        send_request(64'd9999999999999999999, CONV_UDEC, 1'b0, 6'd0);
        send_request(64'd10000000000000000000, CONV_UDEC, 1'b1, 6'd21);
    endtask

    // sign handling, saturation of the width, longest streams
    task automatic test_special_cases();
        // twenty digit unsigned maximum, bare and padded
        send_request(64'hffff_ffff_ffff_ffff, CONV_UDEC, 1'b0, 6'd0);
        send_request(64'hffff_ffff_ffff_ffff, CONV_UDEC, 1'b0, 6'd25);
        // most negative value prints its full magnitude
        send_request(64'h8000_0000_0000_0000, CONV_SDEC, 1'b0, 6'd0);
        send_request(64'h8000_0000_0000_0000, CONV_SDEC, 1'b1, 6'd30);
        // minus one: width zero stays zero, width one leaves no pad
        send_request(64'hffff_ffff_ffff_ffff, CONV_SDEC, 1'b0, 6'd0);
        send_request(64'hffff_ffff_ffff_ffff, CONV_SDEC, 1'b1, 6'd1);
        send_request(64'hffff_ffff_ffff_ffff, CONV_SDEC, 1'b1, 6'd5);
        // width 63 saturates to 62
        send_request(64'hdead_beef, CONV_HEX, 1'b1, 6'd63);
        send_request(64'h00ab_cdef, CONV_PTR, 1'b0, 6'd63);
        send_request(-64'sd42, CONV_SDEC, 1'b1, 6'd63);
        send_request(64'd7, CONV_UDEC, 1'b1, 6'd63);
        send_request(64'd123, CONV_UDEC, 1'b0, 6'd62);
        send_request(64'hffff_ffff_ffff_ffff, CONV_PTR, 1'b1, 6'd16);
    endtask

    // random requests biased toward digit-count edges and short fields
    task automatic test_random_traffic(input int count, input int s_pct,
                                       input int r_pct);
        logic [IN_VALUE_W-1:0] value;
        logic [IN_VALUE_W-1:0] p;
        logic [WIDTH_W-1:0]    width;
        t_conv                 conv;
        int                    k;

        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) begin
            case ($urandom_range(0, 5))
                0: value = {$urandom, $urandom};
                1: value = 64'($urandom_range(0, 999));
                // small negatives
                2: value = 64'd0 - 64'($urandom_range(1, 999));
                // powers of ten and one below, where the digit count steps
                3: begin
                    k = $urandom_range(0, 19);
                    p = 64'd1;
                    repeat (k) p = p * 10;
                    value = p - 64'($urandom_range(0, 1));
                end
                4: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
                default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            conv = t_conv'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7)
                width = WIDTH_W'($urandom_range(0, 24));
            else
                width = WIDTH_W'($urandom_range(0, 63));
            send_request(value, conv, 1'($urandom_range(0, 1)), width);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_value       <= '0;
        i_conversion  <= CONV_UDEC;
        i_zero_pad    <= 1'b0;
        i_width       <= '0;
        send_idle_pct = 13;
        recv_idle_pct = 73;
        requests_sent = 0;
        chars_checked = 0;
        error_count   = 0;
        cycle_count   = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the first flow-control setting
        test_conversion_kinds();
        test_special_cases();

        // slow receiver, then slow sender, then full speed
        test_random_traffic(140, 13, 73);
        test_random_traffic(140, 73, 13);
        test_random_traffic(140, 0, 0);

        push <= 1'b0;

        // wait for every owed character, then watch for strays
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d characters, all four conversions",
                 requests_sent, chars_checked);
        $display("flow control: slow receiver, slow sender, no idling; %0d errors",
                 error_count);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/iaf_pkg.sv
rtl/iaf_front.sv
rtl/iaf_queue.sv
rtl/iaf_back.sv
rtl/integer_to_ascii_formatter_unit.sv
sim/testbench.sv
